// File: design/cpc_pkg.sv
// Shared types and constants for the cyclic polynomial convolution block.
// No dependencies; every other design file but cpc_chan_if refers to this package by scope.
package cpc_pkg;

   localparam int COEFF_W    = 16;
   localparam int INDEX_W    = 10;
   localparam int TERM_W     = 11;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 1;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MODULUS    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TERM_COUNT = 1'd1;

   localparam logic [COEFF_W-1:0] MODULUS_RESET    = 16'd2048;
   localparam logic [TERM_W-1:0]  TERM_COUNT_RESET = 11'd509;

   // item operation codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_FETCH = 1'b1;

   // remainder unit operand select
   localparam logic [1:0] DIV_SRC_A   = 2'd0;
   localparam logic [1:0] DIV_SRC_B   = 2'd1;
   localparam logic [1:0] DIV_SRC_ACC = 2'd2;

   typedef struct packed {
      logic               operation;
      logic [COEFF_W-1:0] a_coeff;
      logic [COEFF_W-1:0] b_coeff;
   } req_item_type;

   typedef struct packed {
      logic [COEFF_W-1:0] coefficient;
      logic [INDEX_W-1:0] index;
      logic               last;
   } rsp_item_type;

   // controller -> datapath
   typedef struct packed {
      logic       op_we;        // write both operand stores
      logic       op_wsel_red;  // write reduced values instead of item payload
      logic       op_rd;        // read both operand stores
      logic       mac_issue;    // operand read feeds the multiply-accumulate
      logic       acc_clr;
      logic       div_start;
      logic [1:0] div_src;
      logic       cap_a;        // hold reduced first operand
      logic       q_latch;
      logic       p_we;
      logic       p_rd;
      logic       rsp_load;
      logic       rsp_last;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic div_done;
      logic rsp_free;
   } status_type;

endpackage

// File: design/cpc_chan_if.sv
// Valid/ready channel carrying one item of a packed payload type.
// Payload types come from cpc_pkg.
interface cpc_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: design/cpc_modrem.sv
// Restoring remainder unit: dividend mod divisor, one dividend bit per cycle.
// Depends on cpc_pkg for the coefficient width.
module cpc_modrem #(
   parameter int DIVIDEND_W = 32,
   localparam int CntW = $clog2(DIVIDEND_W + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [DIVIDEND_W-1:0]       dividend,
   input  logic [cpc_pkg::COEFF_W-1:0] divisor,
   output logic                        done,
   output logic [cpc_pkg::COEFF_W-1:0] remainder
);

   localparam int RemW = cpc_pkg::COEFF_W;

   logic [DIVIDEND_W-1:0] shreg_ff, shreg_in;
   logic [RemW-1:0]       rem_ff, rem_in;
   logic [CntW-1:0]       cnt_ff, cnt_in;
   logic                  done_ff, done_in;
   logic [RemW:0]         trial;
   logic [RemW:0]         diff;
   logic                  ge;

   always_comb begin
      trial = {rem_ff, shreg_ff[DIVIDEND_W-1]};
      diff  = trial - {1'b0, divisor};
      ge    = (trial >= {1'b0, divisor});
   end

   always_comb begin
      shreg_in = shreg_ff;
      rem_in   = rem_ff;
      cnt_in   = cnt_ff;
      done_in  = 1'b0;
      if (start) begin
         shreg_in = dividend;
         rem_in   = '0;
         cnt_in   = CntW'(DIVIDEND_W);
      end else if (cnt_ff != '0) begin
         shreg_in = shreg_ff << 1;
         rem_in   = ge ? diff[RemW-1:0] : trial[RemW-1:0];
         cnt_in   = cnt_ff - CntW'(1);
         done_in  = (cnt_ff == CntW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      shreg_ff <= shreg_in;
      rem_ff   <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// File: design/cpc_datapath.sv
// Datapath: operand and product stores, multiply-accumulate, remainder unit
// and the result register. Depends on cpc_pkg and cpc_modrem.
module cpc_datapath #(
   parameter int MAX_TERMS  = 1024,
   parameter int COEFF_BITS = 16,
   localparam int AddrW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cpc_pkg::cmd_type            cmd,
   output cpc_pkg::status_type         stat,
   input  logic [AddrW-1:0]            op_waddr,
   input  logic [AddrW-1:0]            a_raddr,
   input  logic [AddrW-1:0]            b_raddr,
   input  logic [AddrW-1:0]            p_addr,
   input  logic [cpc_pkg::INDEX_W-1:0] rsp_index,
   input  logic [cpc_pkg::COEFF_W-1:0] modulus,
   input  logic [cpc_pkg::COEFF_W-1:0] req_a_coeff,
   input  logic [cpc_pkg::COEFF_W-1:0] req_b_coeff,
   input  logic                        rsp_ready,
   output logic                        rsp_valid,
   output cpc_pkg::rsp_item_type       rsp_item
);

   localparam int CoefW  = cpc_pkg::COEFF_W;
   localparam int StoreW = (COEFF_BITS < CoefW) ? COEFF_BITS : CoefW;
   localparam int ProdW  = 2 * StoreW;
   localparam int AccW   = ProdW + $clog2(MAX_TERMS);

   logic [StoreW-1:0] a_mem_ff [MAX_TERMS];
   logic [StoreW-1:0] b_mem_ff [MAX_TERMS];
   logic [CoefW-1:0]  p_mem_ff [MAX_TERMS];

   logic [StoreW-1:0] a_rd_ff, b_rd_ff;
   logic [StoreW-1:0] a_wdata, b_wdata;
   logic [StoreW-1:0] ra_ff;
   logic [ProdW-1:0]  prod_ff, prod_in;
   logic              v1_ff, v2_ff;
   logic [AccW-1:0]   acc_ff;
   logic [CoefW-1:0]  q_ff;
   logic [AccW-1:0]   div_dividend;
   logic              div_done;
   logic [CoefW-1:0]  div_rem;
   logic [CoefW-1:0]  p_rd_ff;
   logic              rsp_valid_ff;
   cpc_pkg::rsp_item_type rsp_item_ff;

   // operand stores: item payload while loading, reduced values afterwards
   always_comb begin
      a_wdata = cmd.op_wsel_red ? ra_ff : req_a_coeff[StoreW-1:0];
      b_wdata = cmd.op_wsel_red ? div_rem[StoreW-1:0] : req_b_coeff[StoreW-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.op_we) begin
         a_mem_ff[op_waddr] <= a_wdata;
         b_mem_ff[op_waddr] <= b_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op_rd) begin
         a_rd_ff <= a_mem_ff[a_raddr];
         b_rd_ff <= b_mem_ff[b_raddr];
      end
   end

   // multiply, register, accumulate
   assign prod_in = a_rd_ff * b_rd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.mac_issue;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (cmd.acc_clr) begin
         acc_ff <= '0;
      end else if (v2_ff) begin
         acc_ff <= acc_ff + AccW'(prod_ff);
      end
   end

   // modulus zero behaves as one
   always_ff @(posedge clock) begin
      if (cmd.q_latch) begin
         q_ff <= (modulus == '0) ? CoefW'(1) : modulus;
      end
      if (cmd.cap_a) begin
         ra_ff <= div_rem[StoreW-1:0];
      end
   end

   always_comb begin
      case (cmd.div_src)
         cpc_pkg::DIV_SRC_A:   div_dividend = AccW'(a_rd_ff);
         cpc_pkg::DIV_SRC_B:   div_dividend = AccW'(b_rd_ff);
         cpc_pkg::DIV_SRC_ACC: div_dividend = acc_ff;
         default:              div_dividend = '0;
      endcase
   end

   cpc_modrem #(
      .DIVIDEND_W (AccW)
   ) u_modrem (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (q_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

   // product store
   always_ff @(posedge clock) begin
      if (cmd.p_we) begin
         p_mem_ff[p_addr] <= div_rem;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.p_rd) begin
         p_rd_ff <= p_mem_ff[p_addr];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_item_ff.coefficient <= p_rd_ff;
         rsp_item_ff.index       <= rsp_index;
         rsp_item_ff.last        <= cmd.rsp_last;
      end
   end

   always_comb begin
      stat.div_done = div_done;
      stat.rsp_free = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// File: design/cpc_ctrl.sv
// Controller: load/fetch bookkeeping and the sequencer for operand reduction,
// slot-by-slot accumulation and final reduction. Depends on cpc_pkg.
module cpc_ctrl #(
   parameter int MAX_TERMS = 1024,
   localparam int AddrW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1,
   localparam int CntW  = $clog2(MAX_TERMS + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_operation,
   output logic                        req_ready,
   input  logic [cpc_pkg::TERM_W-1:0]  term_count,
   output cpc_pkg::cmd_type            cmd,
   input  cpc_pkg::status_type         stat,
   output logic [AddrW-1:0]            op_waddr,
   output logic [AddrW-1:0]            a_raddr,
   output logic [AddrW-1:0]            b_raddr,
   output logic [AddrW-1:0]            p_addr,
   output logic [cpc_pkg::INDEX_W-1:0] rsp_index
);

   localparam int IndexW = cpc_pkg::INDEX_W;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_FETCH     = 4'd1;
   localparam logic [3:0] S_RED_RD    = 4'd2;
   localparam logic [3:0] S_RED_DA    = 4'd3;
   localparam logic [3:0] S_RED_WA    = 4'd4;
   localparam logic [3:0] S_RED_WB    = 4'd5;
   localparam logic [3:0] S_MAC       = 4'd6;
   localparam logic [3:0] S_DRAIN1    = 4'd7;
   localparam logic [3:0] S_DRAIN2    = 4'd8;
   localparam logic [3:0] S_ACC_START = 4'd9;
   localparam logic [3:0] S_ACC_WAIT  = 4'd10;

   logic [3:0]       state_ff, state_in;
   logic [AddrW-1:0] load_pos_ff, load_pos_in;
   logic [AddrW-1:0] fetch_pos_ff, fetch_pos_in;
   logic             ready_ff, ready_in;
   logic [CntW-1:0]  len_ff, len_in;
   logic [AddrW-1:0] i_ff, i_in;
   logic [AddrW-1:0] j_ff, j_in;
   logic [AddrW-1:0] k_ff, k_in;
   logic [AddrW-1:0] fetch_idx_ff, fetch_idx_in;
   logic             fetch_last_ff, fetch_last_in;

   logic [CntW-1:0]  n_eff;
   logic             accept;
   logic             i_last, k_last;
   logic [AddrW-1:0] load_pos_eff;
   logic [CntW-1:0]  load_next;
   logic [CntW-1:0]  fetch_next;
   logic             fetch_final;
   logic [AddrW-1:0] j_dec;

   // term count clamped to 1..MAX_TERMS
   always_comb begin
      if (term_count == '0) begin
         n_eff = CntW'(1);
      end else if (32'(term_count) > 32'(MAX_TERMS)) begin
         n_eff = CntW'(MAX_TERMS);
      end else begin
         n_eff = CntW'(term_count);
      end
   end

   always_comb begin
      accept       = req_valid && (state_ff == S_IDLE);
      i_last       = (CntW'(i_ff) + CntW'(1)) == len_ff;
      k_last       = (CntW'(k_ff) + CntW'(1)) == len_ff;
      load_pos_eff = ready_ff ? '0 : load_pos_ff;
      load_next    = CntW'(load_pos_eff) + CntW'(1);
      fetch_next   = CntW'(fetch_pos_ff) + CntW'(1);
      fetch_final  = (fetch_next >= len_ff);
      j_dec        = (j_ff == '0) ? AddrW'(len_ff - CntW'(1)) : j_ff - AddrW'(1);
   end

   always_comb begin
      state_in      = state_ff;
      load_pos_in   = load_pos_ff;
      fetch_pos_in  = fetch_pos_ff;
      ready_in      = ready_ff;
      len_in        = len_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      fetch_idx_in  = fetch_idx_ff;
      fetch_last_in = fetch_last_ff;
      cmd           = '0;
      cmd.rsp_last  = fetch_last_ff;
      req_ready     = 1'b0;
      op_waddr      = i_ff;
      a_raddr       = i_ff;
      b_raddr       = i_ff;
      p_addr        = k_ff;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               if (req_operation == cpc_pkg::OP_LOAD) begin
                  // a load drops any finished product
                  cmd.op_we = 1'b1;
                  op_waddr  = load_pos_eff;
                  ready_in  = 1'b0;
                  if (ready_ff) begin
                     fetch_pos_in = '0;
                  end
                  if (load_next >= n_eff) begin
                     load_pos_in = '0;
                     len_in      = n_eff;
                     cmd.q_latch = 1'b1;
                     i_in        = '0;
                     state_in    = S_RED_RD;
                  end else begin
                     load_pos_in = AddrW'(load_next);
                  end
               end else if (ready_ff) begin
                  cmd.p_rd      = 1'b1;
                  p_addr        = fetch_pos_ff;
                  fetch_idx_in  = fetch_pos_ff;
                  fetch_last_in = fetch_final;
                  fetch_pos_in  = fetch_final ? '0 : AddrW'(fetch_next);
                  state_in      = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_RED_RD: begin
            cmd.op_rd = 1'b1;
            state_in  = S_RED_DA;
         end
         S_RED_DA: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = cpc_pkg::DIV_SRC_A;
            state_in      = S_RED_WA;
         end
         S_RED_WA: begin
            if (stat.div_done) begin
               cmd.cap_a     = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_src   = cpc_pkg::DIV_SRC_B;
               state_in      = S_RED_WB;
            end
         end
         S_RED_WB: begin
            if (stat.div_done) begin
               cmd.op_we       = 1'b1;
               cmd.op_wsel_red = 1'b1;
               if (i_last) begin
                  i_in        = '0;
                  j_in        = '0;
                  k_in        = '0;
                  cmd.acc_clr = 1'b1;
                  state_in    = S_MAC;
               end else begin
                  i_in     = i_ff + AddrW'(1);
                  state_in = S_RED_RD;
               end
            end
         end
         S_MAC: begin
            // slot k gathers a[i] * b[(k - i) mod n]
            cmd.op_rd     = 1'b1;
            cmd.mac_issue = 1'b1;
            b_raddr       = j_ff;
            if (i_last) begin
               state_in = S_DRAIN1;
            end else begin
               i_in = i_ff + AddrW'(1);
               j_in = j_dec;
            end
         end
         S_DRAIN1: begin
            state_in = S_DRAIN2;
         end
         S_DRAIN2: begin
            state_in = S_ACC_START;
         end
         S_ACC_START: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = cpc_pkg::DIV_SRC_ACC;
            state_in      = S_ACC_WAIT;
         end
         S_ACC_WAIT: begin
            if (stat.div_done) begin
               cmd.p_we = 1'b1;
               if (k_last) begin
                  ready_in     = 1'b1;
                  fetch_pos_in = '0;
                  state_in     = S_IDLE;
               end else begin
                  k_in        = k_ff + AddrW'(1);
                  j_in        = k_ff + AddrW'(1);
                  i_in        = '0;
                  cmd.acc_clr = 1'b1;
                  state_in    = S_MAC;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         load_pos_ff  <= '0;
         fetch_pos_ff <= '0;
         ready_ff     <= 1'b0;
         len_ff       <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         load_pos_ff  <= load_pos_in;
         fetch_pos_ff <= fetch_pos_in;
         ready_ff     <= ready_in;
         len_ff       <= len_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      fetch_idx_ff  <= fetch_idx_in;
      fetch_last_ff <= fetch_last_in;
   end

   assign rsp_index = IndexW'(fetch_idx_ff);

endmodule

// File: design/cyclic_poly_convolution_mod_q.sv
// Top level of the cyclic polynomial convolution modulo (x^N - 1, q).
// Depends on cpc_pkg, cpc_chan_if, cpc_ctrl and cpc_datapath.
// Usage
//  - req_port carries items: operation LOAD writes one a/b coefficient pair at
//    the next index (lowest power first); FETCH asks for the next product
//    coefficient. rsp_port returns coefficient, index and last.
//  - The N-th load (N = term_count clamped to 1..MAX_TERMS) starts the
//    product; req_port.ready stays low until it is finished.
//  - Product work: one multiply-accumulate per cycle over the N*N partial
//    products, plus the bit-serial remainder unit over a W-bit dividend,
//    W = 2*min(COEFF_BITS,16) + log2(MAX_TERMS) (42 by default), run for
//    every operand and every result slot.
//  - Other loads leave the block idle and ready. A fetch reads the product
//    store, then loads the result register; a fetch before the product is
//    ready returns nothing. Fetching wraps to index 0 after the item marked last.
//  - The result register decouples the sides: loads are still taken while a
//    result waits; a fetch waits in the controller until that slot frees.
//  - csr_wr_en writes modulus (index 0) or term_count (index 1); write only
//    while idle.
//  - Reset (synchronous) restores modulus 2048, term_count 509, empties the
//    result register and drops any product. Stores are not cleared.
module cyclic_poly_convolution_mod_q #(
   parameter int MAX_TERMS  = 1024,
   parameter int COEFF_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   cpc_chan_if.sink                       req_port,
   cpc_chan_if.source                     rsp_port,
   input  logic                           csr_wr_en,
   input  logic [cpc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cpc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int AddrW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

   logic [cpc_pkg::COEFF_W-1:0] modulus_ff;
   logic [cpc_pkg::TERM_W-1:0]  term_count_ff;

   cpc_pkg::cmd_type      cmd;
   cpc_pkg::status_type   stat;
   cpc_pkg::rsp_item_type rsp_item;
   logic [AddrW-1:0]      op_waddr, a_raddr, b_raddr, p_addr;
   logic [cpc_pkg::INDEX_W-1:0] rsp_index;
   logic                  req_ready;
   logic                  rsp_valid;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff    <= cpc_pkg::MODULUS_RESET;
         term_count_ff <= cpc_pkg::TERM_COUNT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            cpc_pkg::REG_MODULUS:    modulus_ff    <= csr_wdata;
            cpc_pkg::REG_TERM_COUNT: term_count_ff <= csr_wdata[cpc_pkg::TERM_W-1:0];
            default: ;
         endcase
      end
   end

   cpc_ctrl #(
      .MAX_TERMS (MAX_TERMS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_port.valid),
      .req_operation (req_port.payload.operation),
      .req_ready     (req_ready),
      .term_count    (term_count_ff),
      .cmd           (cmd),
      .stat          (stat),
      .op_waddr      (op_waddr),
      .a_raddr       (a_raddr),
      .b_raddr       (b_raddr),
      .p_addr        (p_addr),
      .rsp_index     (rsp_index)
   );

   cpc_datapath #(
      .MAX_TERMS  (MAX_TERMS),
      .COEFF_BITS (COEFF_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .op_waddr    (op_waddr),
      .a_raddr     (a_raddr),
      .b_raddr     (b_raddr),
      .p_addr      (p_addr),
      .rsp_index   (rsp_index),
      .modulus     (modulus_ff),
      .req_a_coeff (req_port.payload.a_coeff),
      .req_b_coeff (req_port.payload.b_coeff),
      .rsp_ready   (rsp_port.ready),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item)
   );

   assign req_port.ready   = req_ready;
   assign rsp_port.valid   = rsp_valid;
   assign rsp_port.payload = rsp_item;

`ifndef SYNTH
   // a waiting result is never overwritten
   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> stat.rsp_free)
      else $error("result register loaded while still occupied");

   // a result appears only after the controller loaded one
   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_port.valid) |-> $past(cmd.rsp_load))
      else $error("result valid rose without a load command");

   // remainder unit never reports done right after a start
   a_div_not_instant: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> !stat.div_done)
      else $error("remainder unit done one cycle after start");
`endif

endmodule
